### src/scc_pkg.sv
package scc_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned SECTOR_W    = 32;
  localparam int unsigned SLOT_FIELD_W = 6;

  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_WRITE_FULL = 2'd1,
    CMD_WRITE_PART = 2'd2,
    CMD_FLUSH      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [SECTOR_W-1:0] sector;
  } scc_in_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    hit;
    logic                    fill;
    logic                    writeback;
    logic [SECTOR_W-1:0]     victim_sector;
    logic                    last;
  } scc_out_t;

endpackage

### src/scc_tag_store.sv
module scc_tag_store import scc_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned TAG_W  = 32
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TAG_W-1:0]  wr_data,
  input  logic [TAG_W-1:0]  key,
  output logic [TAG_W-1:0]  rd_tag,
  output logic              match
);

  // Tag memory with one write port and one registered read port.
  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_tag_r <= mem[rd_addr];
    end
  end

  // The single comparator shared by every step of the lookup.
  assign rd_tag = rd_tag_r;
  assign match  = (rd_tag_r == key);

endmodule

### src/sector_cache_clock_policy.sv
// Tag and replacement controller for a fully associative, write-back cache of
// disk sectors with clock (second-chance) replacement. A request is taken when
// start is high and busy is low; each result appears on out_result for exactly
// one cycle with out_valid high, and the receiver cannot stall it, so it must
// capture every strobe. A read or write first walks the tag memory one slot per
// cycle through a single comparator and stops at the first hit. On a miss the
// clock hand then advances one slot per cycle, clearing referenced marks, until
// it finds a free slot or one whose mark is clear; then the victim tag is read
// and the result reported. A flush scans the slots one per cycle and emits one
// write-back result per dirty slot, the last one marked with last; with nothing
// dirty it answers with a single all-zero result marked last on the next cycle.
// The tag memory needs no clearing after reset because a tag is only used while
// its valid mark is set. Sectors keep their low SECTOR_BITS bits (max SECTOR_W).
module sector_cache_clock_policy import scc_pkg::*; #(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  scc_in_t  in_req,
  output logic     out_valid,
  output scc_out_t out_result
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned TAG_W  = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_VICT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              issue_r, issue_nxt;
  logic              chk_r, chk_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [TAG_W-1:0]  key_r, key_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] hand_r, hand_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  dirty_r, dirty_nxt;
  logic [SLOTS-1:0]  ref_r, ref_nxt;
  logic              out_valid_r, out_valid_nxt;
  scc_out_t          out_r, out_nxt;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [TAG_W-1:0]  rd_tag;
  logic              tag_match;
  logic              is_write;
  logic              any_dirty;
  logic              victim_wb;
  logic [SLOT_W-1:0] hand_inc;
  logic [SLOT_W-1:0] idx_inc;

  scc_tag_store #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W),
    .TAG_W  (TAG_W)
  ) u_tag_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (hand_r),
    .wr_data (key_r),
    .key     (key_r),
    .rd_tag  (rd_tag),
    .match   (tag_match)
  );

  assign is_write  = (cmd_r == CMD_WRITE_FULL) || (cmd_r == CMD_WRITE_PART);
  assign any_dirty = |(valid_r & dirty_r);
  assign victim_wb = valid_r[hand_r] & dirty_r[hand_r];
  assign hand_inc  = (hand_r == LAST_SLOT) ? '0 : SLOT_W'(hand_r + 1'b1);
  assign idx_inc   = SLOT_W'(idx_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    chk_nxt       = chk_r;
    chk_idx_nxt   = chk_idx_r;
    key_nxt       = key_r;
    cmd_nxt       = cmd_r;
    hand_nxt      = hand_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    ref_nxt       = ref_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt   = in_req.sector[TAG_W-1:0];
          cmd_nxt   = in_req.command;
          idx_nxt   = '0;
          issue_nxt = 1'b1;
          chk_nxt   = 1'b0;
          if (in_req.command == CMD_FLUSH) begin
            if (any_dirty) begin
              state_nxt = ST_FLUSH;
            end else begin
              // Nothing to clean: a single empty result closes the flush.
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              out_nxt.last  = 1'b1;
            end
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        // Issue one tag read per cycle; the tag read last cycle is compared now.
        rd_en       = issue_r;
        rd_addr     = idx_r;
        chk_nxt     = issue_r;
        chk_idx_nxt = idx_r;
        if (issue_r) begin
          if (idx_r == LAST_SLOT) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        if (chk_r && valid_r[chk_idx_r] && tag_match) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.slot           = SLOT_FIELD_W'(chk_idx_r);
          out_nxt.hit            = 1'b1;
          out_nxt.last           = 1'b1;
          ref_nxt[chk_idx_r]     = 1'b1;
          if (is_write) begin
            dirty_nxt[chk_idx_r] = 1'b1;
          end
          state_nxt              = ST_IDLE;
        end else if (chk_r && (chk_idx_r == LAST_SLOT)) begin
          state_nxt = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // Second chance: a referenced slot loses its mark and the hand moves on.
        if (!valid_r[hand_r] || !ref_r[hand_r]) begin
          rd_en     = 1'b1;
          rd_addr   = hand_r;
          state_nxt = ST_VICT;
        end else begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_inc;
        end
      end

      ST_VICT: begin
        out_valid_nxt         = 1'b1;
        out_nxt               = '0;
        out_nxt.slot          = SLOT_FIELD_W'(hand_r);
        out_nxt.fill          = (cmd_r != CMD_WRITE_FULL);
        out_nxt.writeback     = victim_wb;
        out_nxt.victim_sector = victim_wb ? SECTOR_W'(rd_tag) : '0;
        out_nxt.last          = 1'b1;
        wr_en                 = 1'b1;
        valid_nxt[hand_r]     = 1'b1;
        dirty_nxt[hand_r]     = is_write;
        ref_nxt[hand_r]       = 1'b1;
        state_nxt             = ST_IDLE;
      end

      ST_FLUSH: begin
        // A dirty slot is read and cleaned now; chk_r and then out_r report it.
        chk_nxt     = valid_r[idx_r] & dirty_r[idx_r];
        chk_idx_nxt = idx_r;
        if (valid_r[idx_r] && dirty_r[idx_r]) begin
          rd_en            = 1'b1;
          rd_addr          = idx_r;
          dirty_nxt[idx_r] = 1'b0;
        end
        if (idx_r != LAST_SLOT) begin
          idx_nxt = idx_inc;
        end
        if (chk_r) begin
          out_valid_nxt         = 1'b1;
          out_nxt               = '0;
          out_nxt.slot          = SLOT_FIELD_W'(chk_idx_r);
          out_nxt.writeback     = 1'b1;
          out_nxt.victim_sector = SECTOR_W'(rd_tag);
          out_nxt.last          = !any_dirty;
          if (!any_dirty) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      hand_r      <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_r       <= chk_nxt;
      hand_r      <= hand_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    key_r     <= key_nxt;
    cmd_r     <= cmd_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

### tb/scc_checker.sv
`timescale 1ns / 1ps

module scc_checker import scc_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  scc_in_t  in_req,
  input  logic     out_valid,
  input  scc_out_t out_result,
  output int       errors,
  output int       outstanding,
  output int       hits,
  output int       misses,
  output int       writebacks
);

  // Shadow copy of the tag store and the replacement marks.
  logic                valid_q [SLOTS];
  logic [SECTOR_W-1:0] tag_q   [SLOTS];
  logic                dirty_q [SLOTS];
  logic                refd_q  [SLOTS];
  int                  hand_q;

  scc_out_t due_results[$];
  int       err_cnt;
  int       hit_cnt;
  int       miss_cnt;
  int       wb_cnt;

  function automatic void clear_cache();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      valid_q[i] = 1'b0;
      tag_q[i]   = '0;
      dirty_q[i] = 1'b0;
      refd_q[i]  = 1'b0;
    end
    hand_q = 0;
    due_results.delete();
  endfunction

  // Works out the results of one request and updates the shadow state.
  function automatic void apply_request(scc_in_t req);
    scc_out_t r;
    int       i;
    int       idx;
    int       n;
    if (cmd_t'(req.command) == CMD_FLUSH) begin
      n = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (valid_q[i] && dirty_q[i]) begin
          r               = '0;
          r.slot          = i[SLOT_FIELD_W-1:0];
          r.writeback     = 1'b1;
          r.victim_sector = tag_q[i];
          dirty_q[i]      = 1'b0;
          due_results.push_back(r);
          n++;
        end
      end
      if (n == 0) begin
        r      = '0;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        r      = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
      end
    end else begin
      idx = -1;
      for (i = 0; i < SLOTS; i++) begin
        if (idx < 0 && valid_q[i] && tag_q[i] == req.sector) idx = i;
      end
      r      = '0;
      r.last = 1'b1;
      if (idx >= 0) begin
        r.slot = idx[SLOT_FIELD_W-1:0];
        r.hit  = 1'b1;
      end else begin
        // Misses are counted here, where the lookup outcome is known.
        miss_cnt++;
        // Second-chance sweep: referenced slots lose their mark and are skipped.
        idx = hand_q;
        while (valid_q[idx] && refd_q[idx]) begin
          refd_q[idx] = 1'b0;
          idx = (idx + 1) % SLOTS;
        end
        hand_q          = idx;
        r.slot          = idx[SLOT_FIELD_W-1:0];
        r.fill          = (cmd_t'(req.command) != CMD_WRITE_FULL);
        r.writeback     = valid_q[idx] && dirty_q[idx];
        r.victim_sector = r.writeback ? tag_q[idx] : '0;
        tag_q[idx]      = req.sector;
        valid_q[idx]    = 1'b1;
        dirty_q[idx]    = 1'b0;
      end
      refd_q[idx] = 1'b1;
      if (cmd_t'(req.command) == CMD_WRITE_FULL || cmd_t'(req.command) == CMD_WRITE_PART)
        dirty_q[idx] = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [SECTOR_W-1:0] want,
                                      logic [SECTOR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  initial begin
    err_cnt  = 0;
    hit_cnt  = 0;
    miss_cnt = 0;
    wb_cnt   = 0;
    clear_cache();
  end

  always @(posedge clk) begin
    scc_out_t want;
    if (!rst_n) begin
      clear_cache();
    end else begin
      if (start && !busy) apply_request(in_req);
      if ($isunknown(out_valid)) begin
        $display("%0t: out_valid unknown", $time);
        err_cnt++;
      end else if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, out_result);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          check_field("slot", 32'(want.slot), 32'(out_result.slot));
          check_field("hit", 32'(want.hit), 32'(out_result.hit));
          check_field("fill", 32'(want.fill), 32'(out_result.fill));
          check_field("writeback", 32'(want.writeback), 32'(out_result.writeback));
          check_field("victim_sector", want.victim_sector, out_result.victim_sector);
          check_field("last", 32'(want.last), 32'(out_result.last));
          if (want.hit) hit_cnt++;
          if (want.writeback) wb_cnt++;
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= due_results.size();
    hits        <= hit_cnt;
    misses      <= miss_cnt;
    writebacks  <= wb_cnt;
  end

endmodule

### tb/sector_cache_clock_policy_tb.sv
`timescale 1ns / 1ps

module sector_cache_clock_policy_tb;
  import scc_pkg::*;

  localparam int unsigned SLOTS      = 64;
  localparam int          POOL_SIZE  = 96;
  localparam int          RAND_REQS  = 400;
  // Settle time given after the last expected result.
  localparam int          DRAIN_CYC  = 4 * SLOTS;
  // Slowest correct run: every request with a full gap, a full miss walk and
  // a full flush scan, with a wide margin on top.
  localparam int          CYCLE_LIMIT = 1000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  scc_in_t  in_req;
  logic     out_valid;
  scc_out_t out_result;

  int errors;
  int outstanding;
  int hits;
  int misses;
  int writebacks;

  int cycles;
  int sent;
  int flushes;
  bit burst;

  logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

  sector_cache_clock_policy #(
    .SLOTS      (SLOTS),
    .SECTOR_BITS(32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  scc_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_result (out_result),
    .errors     (errors),
    .outstanding(outstanding),
    .hits       (hits),
    .misses     (misses),
    .writebacks (writebacks)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sector_cache_clock_policy_tb NOT OK");
      $finish;
    end
  end

  // Issues one request. The idle gap in front of it is drawn per request,
  // except in burst stretches where requests follow back to back. When the
  // gap is zero, start stays high from the previous request so that it is
  // never lowered and raised again in the same time step.
  task automatic issue(cmd_t cmd, logic [SECTOR_W-1:0] sector);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= '{command: cmd, sector: sector};
    start  <= 1'b1;
    // The request is taken at the first edge where busy is seen low.
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (cmd == CMD_FLUSH) flushes++;
  endtask

  // Holds the sender off until every expected result has come back. The
  // outstanding count is a registered copy, so the loop waits for a clock
  // edge before it trusts the count.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int   i;
    int   blk;
    int   span;
    int   pick;
    cmd_t cmd;
    logic [SECTOR_W-1:0] sec;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    burst   = 1'b0;
    sent    = 0;
    flushes = 0;

    // The working set mixes the sector extremes with random sector numbers.
    sector_pool[0] = '0;
    sector_pool[1] = '1;
    sector_pool[2] = 32'h8000_0000;
    sector_pool[3] = 32'h0000_0001;
    for (i = 4; i < POOL_SIZE; i++) sector_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Misses into free slots for each kind of request, a hit
    // that turns a clean line dirty, a flush with several dirty lines, a flush
    // with nothing dirty, and the extremes of the sector number.
    issue(CMD_READ, 32'h0000_0000);
    issue(CMD_WRITE_FULL, 32'hFFFF_FFFF);
    issue(CMD_WRITE_PART, 32'h5555_5555);
    issue(CMD_READ, 32'hAAAA_AAAA);
    issue(CMD_READ, 32'h0000_0000);
    issue(CMD_WRITE_FULL, 32'h0000_0000);
    issue(CMD_WRITE_PART, 32'hFFFF_FFFF);
    issue(CMD_FLUSH, 32'h1234_5678);
    issue(CMD_FLUSH, 32'hFFFF_FFFF);
    issue(CMD_READ, 32'h8000_0000);
    issue(CMD_WRITE_FULL, 32'h0000_0001);
    issue(CMD_READ, 32'h0000_0001);
    issue(CMD_WRITE_PART, 32'h7FFF_FFFF);
    issue(CMD_FLUSH, 32'h0000_0000);
    quiesce();

    // Random part, in blocks of 50 requests. Each block draws its own working
    // set size: small sets give mostly hits, sets larger than the cache force
    // the clock sweep to evict, often dirty lines. Some blocks run without
    // idle gaps at all.
    for (blk = 0; blk < RAND_REQS / 50; blk++) begin
      span  = $urandom_range(8, POOL_SIZE);
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 50; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      cmd = CMD_READ;
        else if (pick < 66) cmd = CMD_WRITE_FULL;
        else if (pick < 92) cmd = CMD_WRITE_PART;
        else                cmd = CMD_FLUSH;
        if ($urandom_range(0, 9) < 8) sec = sector_pool[$urandom_range(0, span - 1)];
        else sec = $urandom;
        issue(cmd, sec);
        if ($urandom_range(0, 24) == 0) quiesce();
      end
    end

    // Drain: wait for every expected result, then give the block time to
    // produce anything extra that the checker would flag.
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Ran %0d requests (%0d flushes) through the %0d-slot clock-policy cache.",
             sent, flushes, SLOTS);
    $display("Results seen: %0d hits, %0d misses, %0d write-backs.",
             hits, misses, writebacks);
    if (errors == 0) begin
      $display("sector_cache_clock_policy_tb OK");
    end else begin
      $display("sector_cache_clock_policy_tb NOT OK");
    end
    $finish;
  end

endmodule

### sector_cache_clock_policy.f
src/scc_pkg.sv
src/scc_tag_store.sv
src/sector_cache_clock_policy.sv
tb/scc_checker.sv
tb/sector_cache_clock_policy_tb.sv
